// File: design/assert_macros.svh
// Assertion macros shared by the current loop output scaler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CLOS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define CLOS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/clos_pkg.sv
// Types and constants of the current loop output scaler.
package clos_pkg;

    localparam int NUM_CHAN    = 4;
    localparam int CH_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int SETUP_W     = 35;
    localparam int MEAS_W      = 16;
    localparam int CUR_W       = 11;
    localparam int QUEUE_DEPTH = 4;

    // Setup register layout.
    localparam int LO_LSB   = 0;
    localparam int HI_LSB   = 16;
    localparam int MODE_BIT = 32;
    localparam int SRC_LSB  = 33;

    // Divide by ten of a magnitude: floor(x * 52429 / 2^19) is exact for x below 2^16.
    localparam int RECIP_10    = 52429;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 33;
    localparam int TQ_W        = 14;

    // Scaling in hundredths of mA.
    localparam int SCALE_4_20 = 1600;
    localparam int SCALE_0_20 = 2000;
    localparam int CUR_BASE   = 400;
    localparam int CUR_FULL   = 2000;
    localparam int NUM_W      = 27;
    localparam int Q_W        = 11;

    typedef enum logic [1:0] {
        SRC_REDOX  = 2'd0,
        SRC_PH     = 2'd1,
        SRC_TEMP   = 2'd2,
        SRC_DISINF = 2'd3
    } t_src;

    // Classified word handed from the front end to the divider.
    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic              zero;
        logic              neg;
        logic              mode;
        logic [MEAS_W-1:0] m;
        logic [MEAS_W-1:0] d;
    } t_item;

endpackage

// File: design/current_loop_output_scaler_unit.sv
// Current loop output scaler: top level joining front end, queue and divider.
//
// Usage: the input channel takes one word per cycle (i_valid, o_stall): a
// channel number and four measurements. The channel's setup register picks
// the source, which is clamped between the 4 mA and 20 mA endpoint values
// and mapped onto 0..2000 hundredths of mA. Each input word gives exactly
// one result word on the output channel (o_valid, i_stall), in order.
// Setup registers are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user writes them while no word is in flight; the block does not enforce it.
// Path: a result passes two front stages, one queue slot, a multiply stage,
// eleven divider stages of one quotient bit each and the output register.
// Throughput: one word per cycle while the receiver does not stall; every stage is pipelined.
// Reset (synchronous, active low) clears all setup registers and empties
// every stage and the queue. When the receiver stalls, the result register
// holds, the divider fills, then the queue, and finally o_stall rises.
module current_loop_output_scaler_unit import clos_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CH_W-1:0]          i_channel,
    input  logic signed [MEAS_W-1:0] i_redox_mv,
    input  logic signed [MEAS_W-1:0] i_ph_value,
    input  logic signed [MEAS_W-1:0] i_temp_tenths,
    input  logic signed [MEAS_W-1:0] i_disinfect_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [SETUP_W-1:0]       i_cfg_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CH_W-1:0]          o_channel_out,
    output logic [CUR_W-1:0]         o_current_centi_ma,
    output logic                     o_span_zero
);

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    clos_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_channel         (i_channel),
        .i_redox_mv        (i_redox_mv),
        .i_ph_value        (i_ph_value),
        .i_temp_tenths     (i_temp_tenths),
        .i_disinfect_value (i_disinfect_value),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_push            (push),
        .o_item            (f_item),
        .i_full            (full)
    );

    clos_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    clos_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (q_valid),
        .i_item             (q_item),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_channel_out      (o_channel_out),
        .o_current_centi_ma (o_current_centi_ma),
        .o_span_zero        (o_span_zero)
    );

endmodule

// File: design/clos_front.sv
// Front end: setup registers, source selection, temperature scaling and clamping.
module clos_front import clos_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CH_W-1:0]          i_channel,
    input  logic signed [MEAS_W-1:0] i_redox_mv,
    input  logic signed [MEAS_W-1:0] i_ph_value,
    input  logic signed [MEAS_W-1:0] i_temp_tenths,
    input  logic signed [MEAS_W-1:0] i_disinfect_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [SETUP_W-1:0]       i_cfg_data,
    output logic                     o_push,
    output t_item                    o_item,
    input  logic                     i_full
);

    logic [SETUP_W-1:0] r_cfg [NUM_CHAN];

    logic                     r_v1;
    logic [CH_W-1:0]          r_ch1;
    logic signed [MEAS_W-1:0] r_lo1;
    logic signed [MEAS_W-1:0] r_hi1;
    logic                     r_mode1;
    logic                     r_temp1;
    logic                     r_tneg1;
    logic signed [MEAS_W-1:0] r_raw1;
    logic [PROD_W-1:0]        r_prod1;

    logic  r_v2;
    t_item r_item2;

    logic [SETUP_W-1:0]       setup;
    t_src                     src;
    logic signed [MEAS_W-1:0] raw;
    logic signed [MEAS_W:0]   t_ext;
    logic [MEAS_W:0]          t_mag;
    logic [PROD_W-1:0]        prod;

    logic [TQ_W-1:0]          tquo;
    logic signed [MEAS_W:0]   tquo_s;
    logic signed [MEAS_W:0]   val;
    logic signed [MEAS_W:0]   lo_e;
    logic signed [MEAS_W:0]   hi_e;
    logic signed [MEAS_W:0]   vmin;
    logic signed [MEAS_W:0]   vmax;
    logic signed [MEAS_W:0]   vcl;
    logic signed [MEAS_W:0]   dd;
    logic signed [MEAS_W:0]   mm;
    t_item                    n_item2;

    logic adv2;
    logic rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        setup = r_cfg[i_channel];
        src   = t_src'(setup[SRC_LSB +: 2]);
        case (src)
            SRC_REDOX: raw = i_redox_mv;
            SRC_PH:    raw = i_ph_value;
            SRC_TEMP:  raw = i_temp_tenths;
            default:   raw = i_disinfect_value;
        endcase
        t_ext = {i_temp_tenths[MEAS_W-1], i_temp_tenths};
        t_mag = t_ext[MEAS_W] ? (MEAS_W+1)'(-t_ext) : t_ext;
        prod  = PROD_W'(t_mag) * PROD_W'(RECIP_10);
    end

    // Second stage: finish the divide by ten, then clamp into the span.
    always_comb begin
        tquo   = r_prod1[RECIP_SHIFT +: TQ_W];
        tquo_s = signed'((MEAS_W+1)'(tquo));
        if (r_temp1) begin
            val = r_tneg1 ? -tquo_s : tquo_s;
        end else begin
            val = {r_raw1[MEAS_W-1], r_raw1};
        end
        lo_e = {r_lo1[MEAS_W-1], r_lo1};
        hi_e = {r_hi1[MEAS_W-1], r_hi1};
        vmin = (hi_e < lo_e) ? hi_e : lo_e;
        vmax = (hi_e < lo_e) ? lo_e : hi_e;
        if (val < vmin) begin
            vcl = vmin;
        end else if (val > vmax) begin
            vcl = vmax;
        end else begin
            vcl = val;
        end
        dd = vcl - vmin;
        mm = vmax - vmin;
        n_item2.ch   = r_ch1;
        n_item2.zero = (r_lo1 == r_hi1);
        n_item2.neg  = (hi_e < lo_e);
        n_item2.mode = r_mode1;
        n_item2.m    = mm[MEAS_W-1:0];
        n_item2.d    = dd[MEAS_W-1:0];
    end

    assign adv2    = !r_v2 || !i_full;
    assign rdy1    = !r_v1 || adv2;
    assign o_stall = !rdy1;
    assign o_push  = r_v2 && !i_full;
    assign o_item  = r_item2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_ch1   <= i_channel;
            r_lo1   <= signed'(setup[LO_LSB +: MEAS_W]);
            r_hi1   <= signed'(setup[HI_LSB +: MEAS_W]);
            r_mode1 <= setup[MODE_BIT];
            r_temp1 <= (src == SRC_TEMP);
            r_tneg1 <= i_temp_tenths[MEAS_W-1];
            r_raw1  <= raw;
            r_prod1 <= prod;
        end
        if (adv2 && r_v1) begin
            r_item2 <= n_item2;
        end
    end

endmodule

// File: design/clos_queue.sv
// Short queue of classified words between the front end and the divider.
`include "assert_macros.svh"
module clos_queue import clos_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `CLOS_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && (r_cnt == '0), "pop from empty queue")
    `CLOS_ASSERT(a_cnt_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1), "queue count did not rise")

endmodule

// File: design/clos_back.sv
// Back end: scaling multiply, pipelined restoring divider and output register.
`include "assert_macros.svh"
module clos_back import clos_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CH_W-1:0]  o_channel_out,
    output logic [CUR_W-1:0] o_current_centi_ma,
    output logic             o_span_zero
);

    localparam int NSTG = Q_W + 1;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic              zero;
        logic              neg;
        logic              mode;
        logic [MEAS_W-1:0] m;
        logic [NUM_W-1:0]  rem;
        logic [Q_W-1:0]    q;
    } t_div;

    t_div             r_st [NSTG];
    logic [NSTG-1:0]  r_sv;
    t_div             n_st [NSTG];
    logic [NSTG:0]    rdy;

    logic             r_ov;
    logic [CH_W-1:0]  r_och;
    logic [CUR_W-1:0] r_ocur;
    logic             r_ozero;
    logic [CUR_W-1:0] n_ocur;
    logic [CUR_W:0]   qup;

    // First stage scales the distance into the span by 100 times the mA range.
    always_comb begin
        n_st[0].ch   = i_item.ch;
        n_st[0].zero = i_item.zero;
        n_st[0].neg  = i_item.neg;
        n_st[0].mode = i_item.mode;
        n_st[0].m    = i_item.m;
        n_st[0].rem  = NUM_W'(i_item.d) *
                       NUM_W'(i_item.mode ? SCALE_0_20 : SCALE_4_20);
        n_st[0].q    = '0;
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s < NSTG; s++) begin : g_div
        localparam int SH = Q_W - s;
        logic [NUM_W-1:0] dv;
        assign dv = NUM_W'(r_st[s-1].m) << SH;
        always_comb begin
            n_st[s] = r_st[s-1];
            if (r_st[s-1].rem >= dv) begin
                n_st[s].rem   = r_st[s-1].rem - dv;
                n_st[s].q[SH] = 1'b1;
            end
        end
    end

    assign rdy[NSTG] = !r_ov || !i_stall;
    for (genvar s = 0; s < NSTG; s++) begin : g_rdy
        assign rdy[s] = !r_sv[s] || rdy[s+1];
    end

    assign o_pop = i_valid && rdy[0];

    // An inverted span maps downward, so the remainder rounds the quotient up.
    always_comb begin
        qup = (CUR_W+1)'(r_st[NSTG-1].q) + (CUR_W+1)'(r_st[NSTG-1].rem != '0);
        if (r_st[NSTG-1].zero) begin
            n_ocur = '0;
        end else if (r_st[NSTG-1].neg) begin
            n_ocur = CUR_W'((CUR_W+1)'(CUR_FULL) - qup);
        end else if (r_st[NSTG-1].mode) begin
            n_ocur = r_st[NSTG-1].q;
        end else begin
            n_ocur = CUR_W'(CUR_BASE) + r_st[NSTG-1].q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_ov <= 1'b0;
        end else begin
            if (rdy[0]) begin
                r_sv[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_sv[k] <= r_sv[k-1];
                end
            end
            if (rdy[NSTG]) begin
                r_ov <= r_sv[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (rdy[NSTG] && r_sv[NSTG-1]) begin
            r_och   <= r_st[NSTG-1].ch;
            r_ocur  <= n_ocur;
            r_ozero <= r_st[NSTG-1].zero;
        end
    end

    assign o_valid            = r_ov;
    assign o_channel_out      = r_och;
    assign o_current_centi_ma = r_ocur;
    assign o_span_zero        = r_ozero;

    `CLOS_ASSERT(a_zero_cur, i_clk, i_rst_n, (r_ov && r_ozero) |-> (r_ocur == '0), "zero span with nonzero current")
    `CLOS_ASSERT(a_cur_range, i_clk, i_rst_n, r_ov |-> (r_ocur <= CUR_W'(CUR_FULL)), "current above full scale")

endmodule

// File: tb/tb.sv
// Self-checking testbench for the current loop output scaler unit.
`timescale 1ns / 100ps

module tb;
    import clos_pkg::*;

    localparam int CLK_HALF       = 1;
    localparam int RESET_CYCLES   = 4;
    localparam int NUM_DIR        = 18;
    localparam int RAND_PHASES    = 7;
    localparam int WORDS_PER_SET  = 150;
    localparam int SETTLE_CYCLES  = 20;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int CENTI          = 100;
    localparam int FULL_MA        = 20;
    localparam int SPAN_4_20_MA   = 16;
    localparam int BASE_CENTI     = 400;
    localparam int TEMP_DIV       = 10;
    localparam int MEAS_MIN       = -32768;
    localparam int MEAS_MAX       = 32767;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [MEAS_W-1:0] redox;
        logic [MEAS_W-1:0] ph;
        logic [MEAS_W-1:0] temp;
        logic [MEAS_W-1:0] dis;
    } meas_word_t;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [CUR_W-1:0] cur;
        logic             zero;
    } loop_reading_t;

    typedef struct packed {
        logic             after_cfg;
        logic             typed;
        meas_word_t       w;
        logic [CUR_W-1:0] cur;
        logic             zero;
    } dir_row_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [CH_W-1:0]          i_channel;
    logic signed [MEAS_W-1:0] i_redox_mv;
    logic signed [MEAS_W-1:0] i_ph_value;
    logic signed [MEAS_W-1:0] i_temp_tenths;
    logic signed [MEAS_W-1:0] i_disinfect_value;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [SETUP_W-1:0]       i_cfg_data;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [CH_W-1:0]          o_channel_out;
    logic [CUR_W-1:0]         o_current_centi_ma;
    logic                     o_span_zero;

    logic [SETUP_W-1:0] chan_setup [NUM_CHAN];
    loop_reading_t      due_currents [$];
    int                 errors = 0;
    int unsigned        cycles = 0;
    int                 tx_calm = 0;
    int                 rx_calm = 0;
    int                 rx_hold = 0;

    current_loop_output_scaler_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_channel          (i_channel),
        .i_redox_mv         (i_redox_mv),
        .i_ph_value         (i_ph_value),
        .i_temp_tenths      (i_temp_tenths),
        .i_disinfect_value  (i_disinfect_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_channel_out      (o_channel_out),
        .o_current_centi_ma (o_current_centi_ma),
        .o_span_zero        (o_span_zero)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [SETUP_W-1:0] pack_setup(input logic [MEAS_W-1:0] lo,
                                                      input logic [MEAS_W-1:0] hi,
                                                      input logic mode, input t_src src);
        return {src, mode, hi, lo};
    endfunction

    // Clamps the selected measurement to the endpoints and maps it onto the loop current.
    function automatic loop_reading_t scale_current(input logic [SETUP_W-1:0] s,
                                                    input meas_word_t w);
        loop_reading_t res;
        int            lo;
        int            hi;
        int            val;
        int            span;
        longint        m;
        longint        d;
        longint        k;
        lo = $signed(s[LO_LSB +: MEAS_W]);
        hi = $signed(s[HI_LSB +: MEAS_W]);
        case (t_src'(s[SRC_LSB +: 2]))
            SRC_REDOX: val = $signed(w.redox);
            SRC_PH:    val = $signed(w.ph);
            SRC_TEMP: begin
                val = $signed(w.temp);
                val = val / TEMP_DIV;
            end
            default:   val = $signed(w.dis);
        endcase
        res.ch   = w.ch;
        res.cur  = '0;
        res.zero = 1'b0;
        span     = hi - lo;
        if (span == 0) begin
            res.zero = 1'b1;
            return res;
        end
        k = s[MODE_BIT] ? FULL_MA : SPAN_4_20_MA;
        if (span > 0) begin
            if (val < lo) val = lo;
            else if (val > hi) val = hi;
            m = span;
            d = val - lo;
            res.cur = CUR_W'((s[MODE_BIT] ? 0 : BASE_CENTI) + (CENTI * k * d) / m);
        end else begin
            // Inverted span: the 4 mA endpoint still gives the low current.
            if (val > lo) val = lo;
            else if (val < hi) val = hi;
            m = -span;
            d = val - hi;
            res.cur = CUR_W'((CENTI * FULL_MA * m - CENTI * k * d) / m);
        end
        return res;
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [SETUP_W-1:0] rand_setup();
        int   sel;
        int   lo;
        int   span;
        logic mode;
        t_src src;
        sel  = $urandom_range(0, 9);
        mode = 1'($urandom_range(0, 1));
        src  = t_src'($urandom_range(0, 3));
        lo   = $urandom_range(0, 60000) - 30000;
        span = $urandom_range(1, 2000);
        case (sel)
            0: return {3'($urandom_range(0, 7)), 32'($urandom)};
            1: return pack_setup(MEAS_W'(lo), MEAS_W'(lo), mode, src);
            2: begin
                if ($urandom_range(0, 1))
                    return pack_setup(16'h8000, 16'h7FFF, mode, src);
                return pack_setup(16'h7FFF, 16'h8000, mode, src);
            end
            default: begin
                if ($urandom_range(0, 1))
                    return pack_setup(MEAS_W'(lo), MEAS_W'(lo + span), mode, src);
                return pack_setup(MEAS_W'(lo + span), MEAS_W'(lo), mode, src);
            end
        endcase
    endfunction

    // Most words put the selected source near the channel's endpoints.
    function automatic meas_word_t rand_word();
        meas_word_t         w;
        logic [SETUP_W-1:0] s;
        int                 a;
        int                 b;
        int                 v;
        w.ch    = CH_W'($urandom_range(0, NUM_CHAN - 1));
        w.redox = MEAS_W'($urandom);
        w.ph    = MEAS_W'($urandom);
        w.temp  = MEAS_W'($urandom);
        w.dis   = MEAS_W'($urandom);
        s = chan_setup[w.ch];
        if ($urandom_range(0, 9) < 7) begin
            a = $signed(s[LO_LSB +: MEAS_W]);
            b = $signed(s[HI_LSB +: MEAS_W]);
            if (a > b) begin
                v = a;
                a = b;
                b = v;
            end
            v = a - 6 + int'($urandom_range(0, b - a + 12));
            if (t_src'(s[SRC_LSB +: 2]) == SRC_TEMP)
                v = v * TEMP_DIV + int'($urandom_range(0, 18)) - 9;
            if (v < MEAS_MIN) v = MEAS_MIN;
            if (v > MEAS_MAX) v = MEAS_MAX;
            case (t_src'(s[SRC_LSB +: 2]))
                SRC_REDOX: w.redox = MEAS_W'(v);
                SRC_PH:    w.ph    = MEAS_W'(v);
                SRC_TEMP:  w.temp  = MEAS_W'(v);
                default:   w.dis   = MEAS_W'(v);
            endcase
        end
        return w;
    endfunction

    task automatic load_setups(input logic [SETUP_W-1:0] v [NUM_CHAN]);
        for (int c = 0; c < NUM_CHAN; c++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(c);
            i_cfg_data <= v[c];
            @(posedge i_clk);
            chan_setup[c] = v[c];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (due_currents.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_word(input meas_word_t w, input logic typed,
                             input loop_reading_t typed_res);
        int gap;
        if (tx_calm > 0) begin
            gap = 0;
            tx_calm--;
        end else if ($urandom_range(0, 99) < 3) begin
            gap = 0;
            tx_calm = $urandom_range(30, 80);
        end else begin
            gap = ($urandom_range(0, 99) < 60) ? 0 : pause_len();
        end
        // Valid stays high across back-to-back words; it drops only for a gap.
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_channel         <= w.ch;
        i_redox_mv        <= w.redox;
        i_ph_value        <= w.ph;
        i_temp_tenths     <= w.temp;
        i_disinfect_value <= w.dis;
        do @(posedge i_clk); while (o_stall);
        due_currents.push_back(typed ? typed_res : scale_current(chan_setup[w.ch], w));
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $realtime,
                     due_currents.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output side: checks accepted words and drives random stalls.
    always @(posedge i_clk) begin
        loop_reading_t got;
        loop_reading_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_channel_out, o_current_centi_ma, o_span_zero};
            if (due_currents.size() == 0) begin
                $display("%0t: unexpected word: channel %0d current %0d span_zero %0d",
                         $realtime, got.ch, got.cur, got.zero);
                errors++;
            end else begin
                want = due_currents.pop_front();
                if (got.ch !== want.ch) begin
                    $display("%0t: channel_out expected %0d actual %0d",
                             $realtime, want.ch, got.ch);
                    errors++;
                end
                if (got.cur !== want.cur) begin
                    $display("%0t: current_centi_ma expected %0d actual %0d",
                             $realtime, want.cur, got.cur);
                    errors++;
                end
                if (got.zero !== want.zero) begin
                    $display("%0t: span_zero expected %0d actual %0d",
                             $realtime, want.zero, got.zero);
                    errors++;
                end
            end
        end
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
            if (rx_calm > 0) rx_calm--;
            else if ($urandom_range(0, 99) < 3) rx_calm = $urandom_range(30, 80);
            else if ($urandom_range(0, 99) < 25) rx_hold = pause_len();
        end
    end

    initial begin
        dir_row_t           dir_tab [NUM_DIR];
        logic [SETUP_W-1:0] new_cfg [NUM_CHAN];
        logic               cfg_done;
        // Reset setup has equal endpoints everywhere, so every word reports a zero span.
        dir_tab = '{
            '{1'b0, 1'b1, '{2'd0, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000}, 11'd0, 1'b1},
            '{1'b0, 1'b1, '{2'd1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, 11'd0, 1'b1},
            '{1'b0, 1'b1, '{2'd2, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000}, 11'd0, 1'b1},
            '{1'b0, 1'b1, '{2'd3, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA}, 11'd0, 1'b1},
            '{1'b1, 1'b1, '{2'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 11'd400, 1'b0},
            '{1'b1, 1'b1, '{2'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 11'd2000, 1'b0},
            '{1'b1, 1'b0, '{2'd0, 16'h0000, 16'h1234, 16'h4321, 16'hFFFF}, 11'd0, 1'b0},
            '{1'b1, 1'b1, '{2'd1, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000}, 11'd0, 1'b0},
            '{1'b1, 1'b1, '{2'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF}, 11'd2000, 1'b0},
            '{1'b1, 1'b0, '{2'd1, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF}, 11'd0, 1'b0},
            '{1'b1, 1'b1, '{2'd2, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000}, 11'd2000, 1'b0},
            '{1'b1, 1'b1, '{2'd2, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF}, 11'd400, 1'b0},
            '{1'b1, 1'b0, '{2'd2, 16'h7FFF, 16'h8000, -16'sd19, 16'h7FFF}, 11'd0, 1'b0},
            '{1'b1, 1'b0, '{2'd2, 16'h8000, 16'h7FFF, 16'sd19, 16'h8000}, 11'd0, 1'b0},
            '{1'b1, 1'b1, '{2'd3, 16'h8000, 16'h8000, 16'h8000, 16'd1234}, 11'd1234, 1'b0},
            '{1'b1, 1'b1, '{2'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF}, 11'd0, 1'b0},
            '{1'b1, 1'b1, '{2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF}, 11'd2000, 1'b0},
            '{1'b1, 1'b0, '{2'd3, 16'h8000, 16'h7FFF, 16'h8000, 16'd999}, 11'd0, 1'b0}
        };
        for (int c = 0; c < NUM_CHAN; c++) chan_setup[c] = '0;
        cfg_done          = 1'b0;
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_channel         <= '0;
        i_redox_mv        <= '0;
        i_ph_value        <= '0;
        i_temp_tenths     <= '0;
        i_disinfect_value <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].after_cfg && !cfg_done) begin
                wait_quiet();
                new_cfg[0] = pack_setup(16'h8000, 16'h7FFF, 1'b0, SRC_REDOX);
                new_cfg[1] = pack_setup(16'h7FFF, 16'h8000, 1'b1, SRC_PH);
                new_cfg[2] = pack_setup(-16'sd1000, 16'sd1000, 1'b0, SRC_TEMP);
                new_cfg[3] = pack_setup(16'sd0, 16'sd2000, 1'b1, SRC_DISINF);
                load_setups(new_cfg);
                cfg_done = 1'b1;
            end
            send_word(dir_tab[i].w, dir_tab[i].typed,
                      {dir_tab[i].w.ch, dir_tab[i].cur, dir_tab[i].zero});
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_quiet();
            for (int c = 0; c < NUM_CHAN; c++) new_cfg[c] = rand_setup();
            load_setups(new_cfg);
            repeat (WORDS_PER_SET) send_word(rand_word(), 1'b0, '0);
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
